// ----- design/alpha_gain_position_tracker_macros.svh -----
// ----------------------------------------------------------------------------
// alpha_gain_position_tracker_macros.svh
// Assertion helpers shared by the checker of the position tracker.
// ----------------------------------------------------------------------------
`ifndef ALPHA_GAIN_POSITION_TRACKER_MACROS_SVH
`define ALPHA_GAIN_POSITION_TRACKER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define AGPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tracker check failed: next-cycle property");

// Consequent must hold in the same cycle as the antecedent.
`define AGPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tracker check failed: same-cycle property");

`endif

// ----- design/agpt_pkg.sv -----
// ----------------------------------------------------------------------------
// agpt_pkg
// Types and fixed constants of the alpha-gain position tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package agpt_pkg;

  localparam int MEAS_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int VAR_W     = 24;
  localparam int DEN_W     = VAR_W + 1;
  localparam int GAIN_W    = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_GAIN      = 2'd2;

  localparam logic [CFG_W-1:0]  PROCESS_NOISE_RST = 16'd1024;
  localparam logic [CFG_W-1:0]  MEAS_NOISE_RST    = 16'd6400;
  localparam logic [CFG_W-1:0]  VEL_GAIN_RST      = 16'd19661;

  localparam logic [VAR_W-1:0]  VAR_RST   = 24'd256;
  localparam logic [VAR_W-1:0]  VAR_MAX   = 24'hFFFFFF;
  localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'h10000;

  typedef struct packed {
    logic                     detected;
    logic signed [MEAS_W-1:0] meas_x;
    logic signed [MEAS_W-1:0] meas_y;
  } in_word_t;

  typedef struct packed {
    logic signed [MEAS_W-1:0] est_x;
    logic signed [MEAS_W-1:0] est_y;
    logic                     track_valid;
  } out_word_t;

  // divider result back to the sequencer
  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] quo;
  } div_res_t;

endpackage

`default_nettype wire

// ----- design/agpt_div.sv -----
// ----------------------------------------------------------------------------
// agpt_div
// Serial restoring divider for the gain: quo = floor(num * 2^16 / den),
// one quotient bit per cycle, zero when den is zero.
// ----------------------------------------------------------------------------
`default_nettype none

module agpt_div
  import agpt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [VAR_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output div_res_t              res
);

  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [GAIN_W-1:0] quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              lsb_r;

  logic [DEN_W:0]    shifted;
  logic              fits;

  // the only nonzero dividend bit below the top is num[0]; the rest are zero
  assign shifted = {rem_r, (cnt_r == CNT_W'(GAIN_W)) ? lsb_r : 1'b0};
  assign fits    = (shifted >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      quo_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= '0;
        if (den == '0) begin
          done_r <= 1'b1;
        end else begin
          rem_r  <= DEN_W'(num >> 1);
          den_r  <= den;
          lsb_r  <= num[0];
          cnt_r  <= CNT_W'(GAIN_W);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= fits ? DEN_W'(shifted - {1'b0, den_r}) : DEN_W'(shifted);
        quo_r <= {quo_r[GAIN_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;

endmodule

`default_nettype wire

// ----- design/alpha_gain_position_tracker.sv -----
// Frames are taken one at a time: in_stall is high from an accepted word until
// its result enters the output register. A frame with no correction (no
// detection, or the seeding detection) skips the divider; a correcting frame runs
// the 17-step serial gain divider once and the shared multiplier thrice per axis.
// Reset: synchronous on rst_n low; control and configuration registers return
// to their defaults, the track is unseeded with zero position and step and variance 256.
// ----------------------------------------------------------------------------
// alpha_gain_position_tracker
// Per-frame predict/correct position tracker with one scalar gain per axis,
// sequenced over a shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_gain_position_tracker
  import agpt_pkg::*;
#(
  parameter int POS_FRAC_BITS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_word_t                 out_data
);

  localparam int POS_W  = POS_FRAC_BITS + 12;
  localparam int STEP_W = POS_FRAC_BITS + 9;
  localparam int CW     = POS_W + 2;
  localparam int MB_W   = CW;
  localparam int PW     = VAR_W + 1 + MB_W;
  localparam int SH     = POS_FRAC_BITS - 4;
  localparam int RND    = (SH > 0) ? (1 << (SH - 1)) : 0;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PRED = 4'd1;
  localparam logic [3:0] ST_DIV  = 4'd2;
  localparam logic [3:0] ST_WAIT = 4'd3;
  localparam logic [3:0] ST_MUL1 = 4'd4;
  localparam logic [3:0] ST_CORR = 4'd5;
  localparam logic [3:0] ST_MUL2 = 4'd6;
  localparam logic [3:0] ST_STEP = 4'd7;
  localparam logic [3:0] ST_MUL3 = 4'd8;
  localparam logic [3:0] ST_VAR  = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [CW:0] v);
    logic signed [POS_W-1:0] r;
    if ((&v[CW:POS_W-1]) || !(|v[CW:POS_W-1])) begin
      r = v[POS_W-1:0];
    end else begin
      r = v[CW] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [STEP_W-1:0] sat_step(input logic signed [CW:0] v);
    logic signed [STEP_W-1:0] r;
    if ((&v[CW:STEP_W-1]) || !(|v[CW:STEP_W-1])) begin
      r = v[STEP_W-1:0];
    end else begin
      r = v[CW] ? {1'b1, {(STEP_W-1){1'b0}}} : {1'b0, {(STEP_W-1){1'b1}}};
    end
    return r;
  endfunction

  // round half up, drop 16 fraction bits
  function automatic logic signed [CW-1:0] round16(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + PW'(32768);
    return CW'(t >>> 16);
  endfunction

  // position to port format: round half up, saturate to 16 bits
  function automatic logic signed [MEAS_W-1:0] to_port(input logic signed [POS_W-1:0] p);
    logic signed [POS_W:0] t;
    logic signed [POS_W:0] s;
    logic signed [MEAS_W-1:0] r;
    t = (POS_W+1)'(p) + (POS_W+1)'(RND);
    s = t >>> SH;
    if ((&s[POS_W:MEAS_W-1]) || !(|s[POS_W:MEAS_W-1])) begin
      r = s[MEAS_W-1:0];
    end else begin
      r = s[POS_W] ? {1'b1, {(MEAS_W-1){1'b0}}} : {1'b0, {(MEAS_W-1){1'b1}}};
    end
    return r;
  endfunction

  logic [CFG_W-1:0] pn_r, mn_r, vg_r;

  logic [3:0]                state_r, state_nxt;
  logic                      ax_r;
  logic                      det_r;
  logic                      seeded_r;
  logic signed [MEAS_W-1:0]  meas_r [2];
  logic signed [POS_W-1:0]   pos_r  [2];
  logic signed [STEP_W-1:0]  step_r [2];
  logic [VAR_W-1:0]          var_r  [2];
  logic signed [POS_W:0]     resid_r;
  logic signed [CW-1:0]      corr_r;
  logic signed [PW-1:0]      prod_r;
  logic                      out_valid_r;
  out_word_t                 out_data_r;

  logic signed [POS_W-1:0]   pred_pos [2];
  logic [VAR_W-1:0]          pred_var [2];
  logic signed [POS_W-1:0]   seed_pos [2];
  logic [DEN_W-1:0]          var_sum  [2];

  logic signed [POS_W-1:0]   pos_sel;
  logic signed [STEP_W-1:0]  step_sel;
  logic [VAR_W-1:0]          var_sel;
  logic signed [POS_W-1:0]   seed_sel;
  logic [GAIN_W-1:0]         k_inv;
  logic [VAR_W-1:0]          ma;
  logic signed [VAR_W:0]     ma_s;
  logic signed [MB_W-1:0]    mb;
  logic signed [PW-1:0]      prod;

  logic                      div_start;
  logic [DEN_W-1:0]          div_den;
  div_res_t                  div_res;
  logic                      in_take;
  logic                      out_free;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r <= PROCESS_NOISE_RST;
      mn_r <= MEAS_NOISE_RST;
      vg_r <= VEL_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROCESS_NOISE: pn_r <= cfg_data;
        CFG_MEAS_NOISE:    mn_r <= cfg_data;
        CFG_VEL_GAIN:      vg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // per-axis predict and seed values
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      pred_pos[i] = sat_pos((CW+1)'(pos_r[i]) + (CW+1)'(step_r[i]));
      var_sum[i]  = {1'b0, var_r[i]} + DEN_W'(pn_r);
      pred_var[i] = var_sum[i][VAR_W] ? VAR_MAX : var_sum[i][VAR_W-1:0];
      seed_pos[i] = POS_W'(meas_r[i]) <<< SH;
    end
  end

  assign pos_sel  = pos_r[ax_r];
  assign step_sel = step_r[ax_r];
  assign var_sel  = var_r[ax_r];
  assign seed_sel = seed_pos[ax_r];
  assign k_inv    = GAIN_ONE - div_res.quo;

  // --------------------------------------------------------------------------
  // shared multiplier
  // --------------------------------------------------------------------------
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      ST_MUL1: begin
        ma = VAR_W'(div_res.quo);
        mb = MB_W'(resid_r);
      end
      ST_MUL2: begin
        ma = VAR_W'(vg_r);
        mb = corr_r;
      end
      ST_MUL3: begin
        ma = var_sel;
        mb = MB_W'($signed({1'b0, k_inv}));
      end
      default: ;
    endcase
  end

  assign ma_s = {1'b0, ma};
  assign prod = ma_s * mb;

  // --------------------------------------------------------------------------
  // gain divider
  // --------------------------------------------------------------------------
  assign div_start = (state_r == ST_DIV);
  assign div_den   = {1'b0, var_sel} + DEN_W'(mn_r);

  agpt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (var_sel),
    .den   (div_den),
    .res   (div_res)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_PRED;
      ST_PRED: state_nxt = (det_r && seeded_r) ? ST_DIV : ST_OUT;
      ST_DIV:  state_nxt = ST_WAIT;
      ST_WAIT: if (div_res.done) state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_CORR;
      ST_CORR: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_STEP;
      ST_STEP: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_VAR;
      ST_VAR:  state_nxt = ax_r ? ST_OUT : ST_DIV;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ax_r     <= 1'b0;
      seeded_r <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        pos_r[i]  <= '0;
        step_r[i] <= '0;
        var_r[i]  <= VAR_RST;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_PRED: begin
          ax_r <= 1'b0;
          for (int i = 0; i < 2; i++) begin
            var_r[i] <= pred_var[i];
            if (det_r && !seeded_r) begin
              pos_r[i]  <= seed_pos[i];
              step_r[i] <= '0;
            end else begin
              pos_r[i] <= pred_pos[i];
            end
          end
          if (det_r) seeded_r <= 1'b1;
        end
        ST_MUL2: pos_r[ax_r]  <= sat_pos((CW+1)'(pos_sel) + (CW+1)'(corr_r));
        ST_STEP: step_r[ax_r] <= sat_step((CW+1)'(step_sel) + (CW+1)'(round16(prod_r)));
        ST_VAR: begin
          var_r[ax_r] <= prod_r[VAR_W+15:16];
          ax_r        <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath words without reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      det_r     <= in_data.detected;
      meas_r[0] <= in_data.meas_x;
      meas_r[1] <= in_data.meas_y;
    end
    if (state_r == ST_DIV) begin
      resid_r <= (POS_W+1)'(seed_sel) - (POS_W+1)'(pos_sel);
    end
    if (state_r == ST_CORR) begin
      corr_r <= round16(prod_r);
    end
    if (state_r == ST_MUL1 || state_r == ST_MUL2 || state_r == ST_MUL3) begin
      prod_r <= prod;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_data_r.est_x       <= to_port(pos_r[0]);
      out_data_r.est_y       <= to_port(pos_r[1]);
      out_data_r.track_valid <= seeded_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- design/agpt_checker.sv -----
// ----------------------------------------------------------------------------
// agpt_checker
// Port-level checks of the position tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "alpha_gain_position_tracker_macros.svh"

module agpt_checker
  import agpt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_data
);

  // hold a stalled result word
  `AGPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `AGPT_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  // one word at a time: busy right after taking a word
  `AGPT_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  // reset drops any pending result
  `AGPT_ASSERT_NOW(a_reset_clears, $past(!rst_n), !out_valid)

endmodule

bind alpha_gain_position_tracker agpt_checker u_agpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ----- tb/agpt_tracker_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// agpt_tracker_checker
// Watches the tuning port and both word channels of the position tracker,
// keeps its own copy of the track state, predicts the estimate for every
// accepted frame and compares each accepted result against the oldest one.
// ----------------------------------------------------------------------------

module agpt_tracker_checker
  import agpt_pkg::*;
#(
  parameter int FRAC = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_word_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_word_t            out_data,
  output int unsigned          mismatches,
  output int unsigned          outstanding
);

  localparam int POS_W   = FRAC + 12;
  localparam int STEP_W  = FRAC + 9;
  localparam int OUT_SH  = FRAC - 4;
  localparam longint SPREAD_TOP = longint'(VAR_MAX);
  localparam longint UNITY      = longint'(GAIN_ONE);

  // tuning copy
  logic [CFG_W-1:0] noise_proc;
  logic [CFG_W-1:0] noise_meas;
  logic [CFG_W-1:0] vel_gain;

  // track state, index 0 is x, 1 is y
  longint pos [2];
  longint step [2];
  longint spread [2];
  bit     seeded;

  out_word_t   estimates [$];
  out_word_t   want;
  int unsigned errs;

  initial begin
    errs = 0;
  end

  function automatic longint clamp_signed(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // round half up, then floor the shift
  function automatic longint round_half_up(longint v, int s);
    if (s <= 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint meas_to_pos(longint m);
    return m * (longint'(1) <<< (FRAC - 4));
  endfunction

  function automatic void fuse_axis(int a, longint meas);
    longint den;
    longint k;
    longint corr;
    den = spread[a] + longint'(noise_meas);
    k   = 0;
    if (den > 0) k = (spread[a] * UNITY) / den;
    corr      = round_half_up(k * (meas_to_pos(meas) - pos[a]), 16);
    pos[a]    = clamp_signed(pos[a] + corr, POS_W);
    step[a]   = clamp_signed(step[a] + round_half_up(longint'(vel_gain) * corr, 16), STEP_W);
    spread[a] = (spread[a] * (UNITY - k)) >>> 16;
  endfunction

  function automatic out_word_t track_frame(in_word_t w);
    out_word_t r;
    longint    mx;
    longint    my;
    longint    ex;
    longint    ey;
    mx = longint'(w.meas_x);
    my = longint'(w.meas_y);
    for (int a = 0; a < 2; a++) begin
      pos[a]    = clamp_signed(pos[a] + step[a], POS_W);
      spread[a] = spread[a] + longint'(noise_proc);
      if (spread[a] > SPREAD_TOP) spread[a] = SPREAD_TOP;
    end
    if (w.detected) begin
      if (!seeded) begin
        pos[0]  = meas_to_pos(mx);
        pos[1]  = meas_to_pos(my);
        step[0] = 0;
        step[1] = 0;
        seeded  = 1'b1;
      end else begin
        fuse_axis(0, mx);
        fuse_axis(1, my);
      end
    end
    ex = clamp_signed(round_half_up(pos[0], OUT_SH), 16);
    ey = clamp_signed(round_half_up(pos[1], OUT_SH), 16);
    r.est_x       = ex[15:0];
    r.est_y       = ey[15:0];
    r.track_valid = seeded;
    return r;
  endfunction

  task automatic flag_field(input string field, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      noise_proc = PROCESS_NOISE_RST;
      noise_meas = MEAS_NOISE_RST;
      vel_gain   = VEL_GAIN_RST;
      for (int a = 0; a < 2; a++) begin
        pos[a]    = 0;
        step[a]   = 0;
        spread[a] = longint'(VAR_RST);
      end
      seeded = 1'b0;
      estimates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROCESS_NOISE: noise_proc = cfg_data;
          CFG_MEAS_NOISE:    noise_meas = cfg_data;
          CFG_VEL_GAIN:      vel_gain   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) estimates.insert(estimates.size(), track_frame(in_data));
      if (out_valid && !out_stall) begin
        if (estimates.size() == 0) begin
          errs++;
          $display("%0t: unexpected word, expected none, actual est_x=%0d est_y=%0d track=%0b",
                   $time, out_data.est_x, out_data.est_y, out_data.track_valid);
        end else begin
          want = estimates.pop_front();
          flag_field("est_x", int'(want.est_x), int'(out_data.est_x));
          flag_field("est_y", int'(want.est_y), int'(out_data.est_y));
          flag_field("track_valid", int'(want.track_valid), int'(out_data.track_valid));
        end
      end
    end
    mismatches  <= errs;
    outstanding <= estimates.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the position tracker with directed frames and then with phases of
// noisy moving targets under several tuning settings, random idling on both
// channels and one long receiver hold-off; the checker judges every result.
// ----------------------------------------------------------------------------

module testbench;
  import agpt_pkg::*;

  localparam int TRACK_FRAC  = 12;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_START  = 2500;
  localparam int HOLD_LEN    = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 115;
  localparam int DRIFT_WORDS = 270;
  localparam int TAIL_CYCLES = 60;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PROCESS_NOISE;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  in_word_t             in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  out_word_t            out_data;

  int unsigned mismatches;
  int unsigned outstanding;
  bit          calm_in = 1'b0;

  // moving target, Q12.4 per frame
  int tgt_x, tgt_y, vel_x, vel_y, jitter;

  always #1 clk = ~clk;

  alpha_gain_position_tracker #(
    .POS_FRAC_BITS(TRACK_FRAC)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  agpt_tracker_checker #(
    .FRAC(TRACK_FRAC)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void restart_target();
    int s;
    tgt_x  = int'($urandom_range(0, 65535)) - 32768;
    tgt_y  = int'($urandom_range(0, 65535)) - 32768;
    s      = 1 << $urandom_range(0, 10);
    vel_x  = int'($urandom_range(0, 2 * s)) - s;
    vel_y  = int'($urandom_range(0, 2 * s)) - s;
    jitter = (1 << $urandom_range(0, 8)) - 1;
  endfunction

  // mostly detections of the target, with misses, junk and extremes mixed in
  function automatic in_word_t next_frame();
    in_word_t w;
    int       roll;
    roll       = $urandom_range(0, 99);
    w.detected = 1'b1;
    w.meas_x   = 16'(clip16(tgt_x + int'($urandom_range(0, 2 * jitter)) - jitter));
    w.meas_y   = 16'(clip16(tgt_y + int'($urandom_range(0, 2 * jitter)) - jitter));
    if (roll < 12) begin
      w.detected = 1'b0;
      w.meas_x   = 16'($urandom);
      w.meas_y   = 16'($urandom);
    end else if (roll < 20) begin
      w.detected = 1'($urandom);
      w.meas_x   = 16'($urandom);
      w.meas_y   = 16'($urandom);
    end else if (roll < 23) begin
      w.meas_x = roll[0] ? 16'sh7FFF : 16'sh8000;
      w.meas_y = roll[1] ? 16'sh7FFF : 16'sh8000;
    end
    tgt_x += vel_x;
    tgt_y += vel_y;
    // bounce off the edges of the field
    if (tgt_x != clip16(tgt_x)) begin
      vel_x = -vel_x;
      tgt_x = clip16(tgt_x);
    end
    if (tgt_y != clip16(tgt_y)) begin
      vel_y = -vel_y;
      tgt_y = clip16(tgt_y);
    end
    if ($urandom_range(0, 49) == 0) restart_target();
    return w;
  endfunction

  task automatic send(input in_word_t w);
    int gap;
    if (!calm_in && $urandom_range(0, 99) == 0) begin
      gap = $urandom_range(1, 70);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    while (!calm_in && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    // hold the word until it is taken
    do @(posedge clk); while (in_stall);
  endtask

  task automatic offer(input logic det, input logic [15:0] mx, input logic [15:0] my);
    in_word_t w;
    w.detected = det;
    w.meas_x   = mx;
    w.meas_y   = my;
    send(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_tuning(input logic [CFG_W-1:0] pn, input logic [CFG_W-1:0] mn,
                            input logic [CFG_W-1:0] vg);
    logic [CFG_W-1:0] vals [3];
    vals = '{pn, mn, vg};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls, one long hold-off, one calm stretch
  initial begin : receiver
    int unsigned n;
    n = 0;
    forever begin
      @(posedge clk);
      n++;
      if (n >= HOLD_START && n < HOLD_START + HOLD_LEN) out_stall <= 1'b1;
      else if (n >= 9000 && n < 14000) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 99) < 31);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL alpha_gain_position_tracker");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // unseeded frames show zero position
    offer(1'b0, 16'h7FFF, 16'h8000);
    offer(1'b0, 16'h1234, 16'hEDCB);
    // seed at opposite corners, then pull hard the other way
    offer(1'b1, 16'h7FFF, 16'h8000);
    offer(1'b0, 16'h0000, 16'hFFFF);
    offer(1'b1, 16'h8000, 16'h7FFF);
    offer(1'b1, 16'h8000, 16'h7FFF);
    offer(1'b1, 16'h7FFF, 16'h8000);
    offer(1'b1, 16'h0000, 16'h0000);
    offer(1'b0, 16'hAAAA, 16'h5555);
    offer(1'b0, 16'h5555, 16'hAAAA);
    offer(1'b0, 16'hFFFF, 16'h0000);
    offer(1'b1, 16'hFFFF, 16'h0001);
    offer(1'b1, 16'h5555, 16'hAAAA);
    drain();

    // near-unity gain: drive step and position into saturation
    set_tuning(PROCESS_NOISE_RST, 16'd1, 16'hFFFF);
    for (int i = 0; i < 8; i++) begin
      offer(i < 6 ? 1'b1 : 1'b0, i[0] ? 16'h8000 : 16'h7FFF, i[0] ? 16'h7FFF : 16'h8000);
    end
    drain();

    restart_target();
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_tuning(16'd0, 16'd1, 16'd0);
        1: set_tuning(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: set_tuning(PROCESS_NOISE_RST, MEAS_NOISE_RST, VEL_GAIN_RST);
        3: set_tuning(16'hFFFF, 16'd1, 16'hFFFF);
        4: set_tuning(16'd0, 16'hFFFF, 16'hFFFF);
        default: set_tuning(16'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom));
      endcase
      calm_in = (ph == 2);
      // long coast lets the variance saturate
      if (ph == 1) begin
        for (int i = 0; i < DRIFT_WORDS; i++) offer(1'b0, 16'($urandom), 16'($urandom));
      end
      for (int i = 0; i < PHASE_WORDS; i++) send(next_frame());
      drain();
    end
    calm_in = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS alpha_gain_position_tracker");
    end else begin
      $display("FAIL alpha_gain_position_tracker");
    end
    $finish;
  end

endmodule
